@@ hw/rtl/olre_pkg.sv @@
`default_nettype none
package olre_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_TOP    = 3'd1;
    localparam logic [2:0] CMD_BOTTOM = 3'd2;
    localparam logic [2:0] CMD_SHIFT  = 3'd3;
    localparam logic [2:0] CMD_RANK   = 3'd4;
    localparam logic [2:0] CMD_ITEM   = 3'd5;

    localparam int FieldW = 11;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_GRAB  = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/olre_ram.sv @@
`default_nettype none
module olre_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/ordered_list_reposition_engine_core.sv @@
`default_nettype none
// Ordered list engine: keeps a list of distinct item numbers in two memories, one
// mapping slot to item and one mapping item to slot. A load or a query steps through
// lookup, result and idle before the next request is accepted. A move also grabs the
// moving item, then reads and writes back every slot that closes up through the one
// write port of each memory, one slot per cycle, then places the item. One request is
// handled at a time; the result register lets the next request in while an earlier
// result waits.
module ordered_list_reposition_engine_core
    import olre_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd[2:0], item[13:3], position[24:14], offset[35:25]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // answer[10:0], status[11]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int NB  = $clog2(MAX_ITEMS + 1);
    localparam int VW  = ((NB > FieldW) ? NB : FieldW) + 1;
    localparam int TW  = ((AW > FieldW) ? AW : FieldW) + 2;
    localparam logic [VW-1:0] MaxV = VW'(MAX_ITEMS);

    state_t state_reg, state_next;
    logic [10:0] cnt_reg;
    logic [2:0]  cmd_reg;
    logic [10:0] item_reg, pos_reg;
    logic [10:0] off_reg;
    logic [10:0] mov_reg, mov_next;
    logic [AW-1:0] wr_reg, wr_next, dst_reg, dst_next;
    logic          up_reg, up_next;
    logic [10:0] ans_reg, ans_next;
    logic        sts_reg, sts_next;
    logic        m_valid_reg;
    logic [11:0] m_data_reg;

    logic          ia_we, so_we;
    logic [AW-1:0] ia_waddr, ia_raddr, so_waddr, so_raddr;
    logic [10:0]   ia_wdata, ia_rdata;
    logic [AW-1:0] so_wdata, so_rdata;

    logic [VW-1:0] n_w, cfg_w, item_w, pos_w, wv_w;
    logic          item_ok, pos_ok, have_slot, wv_ok, tgt_ok;
    logic [TW-1:0] tgt;
    logic [AW-1:0] step_addr, src;
    logic [10:0]   wv;
    logic          s_acc;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'd0, m_data_reg};

    // Effective count and range checks.
    assign cfg_w     = VW'(cnt_reg);
    assign n_w       = (cfg_w < MaxV) ? cfg_w : MaxV;
    assign item_w    = VW'(item_reg);
    assign pos_w     = VW'(pos_reg);
    assign item_ok   = (item_w != '0) && (item_w <= MaxV);
    assign pos_ok    = (pos_w != '0) && (pos_w <= n_w);
    assign have_slot = item_ok && (VW'(so_rdata) < n_w);
    assign tgt       = TW'(so_rdata) + TW'($signed(off_reg));
    assign tgt_ok    = !tgt[TW-1] && (tgt < TW'(n_w));
    assign src       = so_rdata;

    // Value being placed and its reverse-map update.
    assign wv        = (state_reg == ST_FINAL) ? mov_reg : ia_rdata;
    assign wv_w      = VW'(wv);
    assign wv_ok     = (wv_w != '0) && (wv_w <= MaxV);
    assign step_addr = up_reg ? wr_reg + AW'(1) : wr_reg - AW'(1);

    // Sequencer: lookup, then read-modify-write one slot per cycle during a move.
    always_comb begin
        logic [VW-1:0] ia_sub, it_sub, sp_sub, wv_sub;
        state_next = state_reg;
        mov_next   = mov_reg;
        wr_next    = wr_reg;
        dst_next   = dst_reg;
        up_next    = up_reg;
        ans_next   = ans_reg;
        sts_next   = sts_reg;
        ia_we      = 1'b0;
        so_we      = 1'b0;
        ia_waddr   = wr_reg;
        ia_wdata   = wv;
        wv_sub     = wv_w - VW'(1);
        so_waddr   = wv_sub[AW-1:0];
        so_wdata   = wr_reg;
        it_sub     = VW'(s_tdata[13:3]) - VW'(1);
        sp_sub     = VW'(s_tdata[24:14]) - VW'(1);
        ia_sub     = pos_w - VW'(1);
        so_raddr   = it_sub[AW-1:0];
        ia_raddr   = sp_sub[AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                ans_next   = '0;
                sts_next   = 1'b1;
                state_next = ST_DONE;
                ia_raddr   = src;
                wr_next    = src;
                case (cmd_reg)
                    CMD_LOAD: begin
                        if (item_ok && pos_ok) begin
                            it_sub   = item_w - VW'(1);
                            ia_we    = 1'b1;
                            ia_waddr = ia_sub[AW-1:0];
                            ia_wdata = item_reg;
                            so_we    = 1'b1;
                            so_waddr = it_sub[AW-1:0];
                            so_wdata = ia_sub[AW-1:0];
                            sts_next = 1'b0;
                        end
                    end
                    CMD_TOP, CMD_BOTTOM, CMD_SHIFT: begin
                        if (have_slot) begin
                            if (cmd_reg == CMD_TOP) begin
                                dst_next = '0;
                                sts_next = 1'b0;
                            end else if (cmd_reg == CMD_BOTTOM) begin
                                sp_sub   = n_w - VW'(1);
                                dst_next = sp_sub[AW-1:0];
                                sts_next = 1'b0;
                            end else begin
                                dst_next = tgt[AW-1:0];
                                sts_next = !tgt_ok;
                            end
                            if (cmd_reg != CMD_SHIFT || tgt_ok) begin
                                state_next = ST_GRAB;
                            end
                        end
                    end
                    CMD_RANK: begin
                        if (have_slot) begin
                            ans_next = 11'(src);
                            sts_next = 1'b0;
                        end
                    end
                    CMD_ITEM: begin
                        if (pos_ok) begin
                            ans_next = ia_rdata;
                            sts_next = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                up_next = (dst_next > src);
            end
            ST_GRAB: begin
                // Moving item is now read; start on the first neighbor.
                mov_next = ia_rdata;
                ia_raddr = step_addr;
                if (wr_reg == dst_reg) begin
                    state_next = ST_FINAL;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                ia_we    = 1'b1;
                so_we    = wv_ok;
                wr_next  = step_addr;
                ia_raddr = up_reg ? step_addr + AW'(1) : step_addr - AW'(1);
                if (step_addr == dst_reg) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                ia_we      = 1'b1;
                so_we      = wv_ok;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 11'd1024;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cnt_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and working registers.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg  <= s_tdata[2:0];
            item_reg <= s_tdata[13:3];
            pos_reg  <= s_tdata[24:14];
            off_reg  <= s_tdata[35:25];
        end
        mov_reg <= mov_next;
        wr_reg  <= wr_next;
        dst_reg <= dst_next;
        up_reg  <= up_next;
        ans_reg <= ans_next;
        sts_reg <= sts_next;
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {sts_reg, ans_reg};
        end
    end

    olre_ram #(.WIDTH(11), .DEPTH(MAX_ITEMS)) u_item_at_slot (
        .aclk  (aclk),
        .we    (ia_we),
        .waddr (ia_waddr),
        .wdata (ia_wdata),
        .raddr (ia_raddr),
        .rdata (ia_rdata)
    );

    olre_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_slot_of_item (
        .aclk  (aclk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .raddr (so_raddr),
        .rdata (so_rdata)
    );

`ifndef NO_ASSERTIONS
    a_onehot : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == ST_LOOK)
        else $error("accepted request not looked up");
    a_wr_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT || state_reg == ST_FINAL) |-> VW'(wr_reg) < n_w)
        else $error("move writes beyond list");
    a_no_write_done : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE || state_reg == ST_IDLE) |-> !ia_we && !so_we)
        else $error("memory written outside a request");
`endif

endmodule
`default_nettype wire

@@ verif/ordered_list_reposition_engine_core_tb.sv @@
`timescale 1ns / 100ps
module ordered_list_reposition_engine_core_tb;
    import olre_pkg::*;

    localparam int LIST_MAX = 1024;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [10:0] item;
        logic [10:0] pos;
        logic [10:0] off;
    } request_t;

    typedef struct packed {
        logic [10:0] answer;
        logic        status;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    ordered_list_reposition_engine_core #(.MAX_ITEMS(LIST_MAX)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    request_t  pending_requests[$];
    response_t expected_responses[$];
    request_t  in_flight;
    int        error_count = 0;
    bit        no_idle = 1'b0;

    // Shadow list state used to predict each response.
    logic [10:0] shadow_item_at[LIST_MAX];
    logic [10:0] shadow_slot_of[LIST_MAX];
    logic [10:0] shadow_count = 11'd1024;

    // Generator-side bookkeeping: items whose slot entry has been written.
    int  gen_list[$];
    int  ever_loaded[$];
    bit  loaded_flag[LIST_MAX + 1];
    int  gen_count;

    initial begin
        for (int i = 0; i < LIST_MAX; i++) begin
            shadow_item_at[i] = '0;
            shadow_slot_of[i] = '0;
        end
        for (int i = 0; i <= LIST_MAX; i++) loaded_flag[i] = 1'b0;
    end

    function automatic bit item_valid(int it);
        return it >= 1 && it <= LIST_MAX;
    endfunction

    function automatic void shadow_place(int slot, int it);
        shadow_item_at[slot] = it[10:0];
        if (item_valid(it)) shadow_slot_of[it - 1] = slot[10:0];
    endfunction

    // Take the entry out of src and reinsert it at dst; the slots between close up.
    function automatic void shadow_move(int src, int dst);
        int it;
        it = shadow_item_at[src];
        if (dst < src) begin
            for (int i = src; i > dst; i--) shadow_place(i, shadow_item_at[i - 1]);
        end else begin
            for (int i = src; i < dst; i++) shadow_place(i, shadow_item_at[i + 1]);
        end
        shadow_place(dst, it);
    endfunction

    function automatic response_t predict_response(request_t rq);
        response_t rs;
        int n, it, pos, off, slot, tgt;
        bit have_slot;
        n = shadow_count > LIST_MAX ? LIST_MAX : shadow_count;
        it = rq.item;
        pos = rq.pos;
        off = $signed(rq.off);
        slot = 0;
        have_slot = 1'b0;
        rs.answer = '0;
        rs.status = STATUS_ERR;
        if (rq.cmd >= CMD_TOP && rq.cmd <= CMD_RANK && item_valid(it)) begin
            slot = shadow_slot_of[it - 1];
            have_slot = slot < n;
        end
        case (rq.cmd)
            CMD_LOAD: begin
                if (item_valid(it) && pos >= 1 && pos <= n) begin
                    shadow_place(pos - 1, it);
                    rs.status = STATUS_OK;
                end
            end
            CMD_TOP: begin
                if (have_slot) begin
                    shadow_move(slot, 0);
                    rs.status = STATUS_OK;
                end
            end
            CMD_BOTTOM: begin
                if (have_slot) begin
                    shadow_move(slot, n - 1);
                    rs.status = STATUS_OK;
                end
            end
            CMD_SHIFT: begin
                tgt = slot + off;
                if (have_slot && tgt >= 0 && tgt < n) begin
                    shadow_move(slot, tgt);
                    rs.status = STATUS_OK;
                end
            end
            CMD_RANK: begin
                if (have_slot) begin
                    rs.answer = slot[10:0];
                    rs.status = STATUS_OK;
                end
            end
            CMD_ITEM: begin
                if (pos >= 1 && pos <= n) begin
                    rs.answer = shadow_item_at[pos - 1];
                    rs.status = STATUS_OK;
                end
            end
            default: ;
        endcase
        return rs;
    endfunction

    // Request driver with random gaps; predicts each request as it is accepted.
    int send_gap = 0;
    always @(posedge aclk) begin
        request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_responses.push_back(predict_response(in_flight));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0 && !no_idle) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    nxt = pending_requests.pop_front();
                    in_flight <= nxt;
                    s_tdata <= {4'b0, nxt.off, nxt.pos, nxt.item, nxt.cmd};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with random back-pressure.
    int stall_left = 0;
    always @(posedge aclk) begin
        response_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.answer = m_tdata[10:0];
                got.status = m_tdata[11];
                if (expected_responses.size() == 0) begin
                    $display("%0t: unexpected response answer=%0d status=%0d",
                             $time, got.answer, got.status);
                    error_count++;
                end else begin
                    want = expected_responses.pop_front();
                    if (got.answer !== want.answer) begin
                        $display("%0t: answer mismatch expected=%0d actual=%0d",
                                 $time, want.answer, got.answer);
                        error_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0 && !no_idle) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                stall_left <= $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void queue_request(int cmd, int it, int pos, int off);
        request_t rq;
        rq.cmd = cmd[2:0];
        rq.item = it[10:0];
        rq.pos = pos[10:0];
        rq.off = off[10:0];
        pending_requests.push_back(rq);
        // A load that succeeds writes the item's slot entry.
        if (cmd == CMD_LOAD && item_valid(it) && pos >= 1 && pos <= gen_count
                && !loaded_flag[it]) begin
            loaded_flag[it] = 1'b1;
            ever_loaded.push_back(it);
        end
    endfunction

    // Item numbers whose reads stay within written entries.
    function automatic int choose_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 8) return $urandom_range(LIST_MAX + 1, 2047);
        if (r < 16 || gen_list.size() == 0)
            return ever_loaded[$urandom_range(0, ever_loaded.size() - 1)];
        return gen_list[$urandom_range(0, gen_list.size() - 1)];
    endfunction

    function automatic int choose_position();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
        return $urandom_range(1, gen_count > 0 ? gen_count : 1);
    endfunction

    function automatic int choose_offset();
        int lim;
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 2047);
        lim = gen_count > 1 ? gen_count - 1 : 1;
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // Wait until every request is answered, then write the list length.
    task automatic write_count(int value);
        while (pending_requests.size() > 0 || expected_responses.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_data <= value[10:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow_count = value[10:0];
        gen_count = value > LIST_MAX ? LIST_MAX : value;
    endtask

    // Load a fresh list of distinct random items into every slot.
    task automatic load_fresh_list(int n);
        int pool[$];
        int order[$];
        for (int i = 1; i <= LIST_MAX; i++) pool.push_back(i);
        pool.shuffle();
        gen_list.delete();
        for (int i = 0; i < n; i++) begin
            gen_list.push_back(pool[i]);
            order.push_back(i + 1);
        end
        order.shuffle();
        foreach (order[k]) queue_request(CMD_LOAD, gen_list[order[k] - 1], order[k], 0);
    endtask

    task automatic random_commands(int n);
        int r, cmd;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6) cmd = CMD_LOAD;
            else if (r < 20) cmd = CMD_TOP;
            else if (r < 34) cmd = CMD_BOTTOM;
            else if (r < 60) cmd = CMD_SHIFT;
            else if (r < 78) cmd = CMD_RANK;
            else if (r < 96) cmd = CMD_ITEM;
            else cmd = $urandom_range(0, 1) ? CMD_BAD6 : CMD_BAD7;
            queue_request(cmd, choose_item(), choose_position(), choose_offset());
        end
    endtask

    initial begin
        int sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a five-entry list, every command and the error cases.
        write_count(5);
        gen_list = '{1, LIST_MAX, 7, 500, 2};
        foreach (gen_list[k]) queue_request(CMD_LOAD, gen_list[k], k + 1, 0);
        queue_request(CMD_LOAD, 0, 1, 0);
        queue_request(CMD_LOAD, 2047, 2047, 2047);
        queue_request(CMD_LOAD, 9, 0, 0);
        queue_request(CMD_LOAD, 9, 6, 0);
        queue_request(CMD_TOP, 500, 0, 0);
        queue_request(CMD_BOTTOM, 1, 0, 0);
        queue_request(CMD_SHIFT, 7, 0, 1);
        queue_request(CMD_SHIFT, 7, 0, -1023);
        queue_request(CMD_SHIFT, 7, 0, 1023);
        queue_request(CMD_SHIFT, 2, 0, -1);
        queue_request(CMD_RANK, LIST_MAX, 0, 0);
        queue_request(CMD_RANK, 0, 0, 0);
        queue_request(CMD_ITEM, 0, 1, 0);
        queue_request(CMD_ITEM, 0, 5, 0);
        queue_request(CMD_ITEM, 0, 6, 0);
        queue_request(CMD_ITEM, 2047, 0, 0);
        queue_request(CMD_BAD6, 1, 1, 0);
        queue_request(CMD_BAD7, 1, 1, 0);

        // Full list, then the same contents under an over-range count.
        write_count(LIST_MAX);
        load_fresh_list(LIST_MAX);
        random_commands(80);
        write_count(2047);
        random_commands(40);

        // Single entry: most earlier items now hold stale slots.
        write_count(1);
        load_fresh_list(1);
        random_commands(30);

        // Empty list: every command fails.
        write_count(0);
        gen_list.delete();
        random_commands(15);

        // Short lists of random length.
        sent = 0;
        while (sent < 350) begin
            write_count($urandom_range(2, 40));
            load_fresh_list(gen_count);
            random_commands(30);
            sent += gen_count + 30;
        end

        // Closing phase at full rate on both sides.
        write_count(2);
        no_idle = 1'b1;
        load_fresh_list(2);
        random_commands(40);

        while (pending_requests.size() > 0 || expected_responses.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (error_count == 0 && expected_responses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
